FILE: hw/rtl/fvlw_pkg.sv
// shared types and constants for the fill valve level watcher
package fvlw_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_NORMAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ALARM  = 2'd3;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] FILL_TIMEOUT_RST = 16'd300;
  localparam logic [CFG_DATA_W-1:0] BLINK_NORMAL_RST = 16'd10;
  localparam logic [CFG_DATA_W-1:0] BLINK_ALARM_RST  = 16'd1;

  // reported fill_mode codes
  localparam logic [1:0] FILL_MODE_WAIT  = 2'd0;
  localparam logic [1:0] FILL_MODE_FILL  = 2'd1;
  localparam logic [1:0] FILL_MODE_EMERG = 2'd2;

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'b001,
    MODE_FILL  = 3'b010,
    MODE_EMERG = 3'b100
  } mode_t;

  typedef struct packed {
    logic low_sensor_pin;
    logic full_sensor_pin;
  } in_item_t;

  typedef struct packed {
    logic       valve_on;
    logic       led_on;
    logic [1:0] fill_mode;
  } out_item_t;

endpackage

FILE: hw/rtl/fill_valve_level_watcher.sv
// fill valve level watcher: debounced level control, fill timeout and run led
//
// usage: each input beat on in_valid/in_ready is one tenth-second tick with the
// low-water and full-water sensor pins. every tick produces exactly one result
// beat on out_valid/out_ready carrying valve_on, led_on and fill_mode.
// cfg_valid/cfg_data/cfg_index write the four 16-bit settings (debounce,
// fill timeout, normal and alarm blink period); cfg_ready is always high and
// settings should only change while no tick is in flight.
// result: an accepted tick's result is registered and shows from the next cycle.
// throughput: one tick per cycle while results are taken; the state update is
// a single pass of counter increment and compare logic between the input
// handshake and the result register.
// stall: the result register holds its beat while out_ready is low; in_ready
// stays high as long as the held beat is taken in the same cycle, so the
// block stalls the input only while a result is waiting and out_ready is low.
// reset: rst_n (synchronous, active low) returns to waiting, clears all
// counters, turns the led off, empties the result register and restores the
// default settings. the emergency state is only left through reset.
module fill_valve_level_watcher #(
  parameter int COUNTER_BITS = fvlw_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fvlw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fvlw_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fvlw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvlw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW   = COUNTER_BITS;
  localparam int CMPW = (CW > fvlw_pkg::CFG_DATA_W) ? CW : fvlw_pkg::CFG_DATA_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [fvlw_pkg::CFG_DATA_W-1:0] debounce_r, timeout_r, blink_norm_r, blink_alarm_r;

  fvlw_pkg::mode_t mode_r, mode_nxt;
  logic [CW-1:0]   stable_r, stable_nxt;
  logic [CW-1:0]   fill_time_r, fill_time_nxt;
  logic [CW-1:0]   blink_r, blink_nxt;
  logic            led_r, led_nxt;

  logic                out_valid_r;
  fvlw_pkg::out_item_t out_data_r, out_data_nxt;

  logic                            in_fire;
  logic [CW-1:0]                   stable_inc, fill_inc, blink_inc;
  logic [fvlw_pkg::CFG_DATA_W-1:0] blink_lim;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // saturating increments
  assign stable_inc = (stable_r == CNT_MAX) ? stable_r : stable_r + 1'b1;
  assign fill_inc   = (fill_time_r == CNT_MAX) ? fill_time_r : fill_time_r + 1'b1;
  assign blink_inc  = (blink_r == CNT_MAX) ? blink_r : blink_r + 1'b1;

  // blink period follows the mode held before this tick
  assign blink_lim = (mode_r == fvlw_pkg::MODE_EMERG) ? blink_alarm_r : blink_norm_r;

  always_comb begin
    led_nxt = led_r;
    if (CMPW'(blink_inc) >= CMPW'(blink_lim)) begin
      led_nxt   = ~led_r;
      blink_nxt = '0;
    end else begin
      blink_nxt = blink_inc;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    stable_nxt    = stable_r;
    fill_time_nxt = fill_time_r;
    case (mode_r)
      fvlw_pkg::MODE_WAIT: begin
        if (!in_data.low_sensor_pin) begin
          if (CMPW'(stable_inc) > CMPW'(debounce_r)) begin
            stable_nxt    = '0;
            fill_time_nxt = '0;
            mode_nxt      = fvlw_pkg::MODE_FILL;
          end else begin
            stable_nxt = stable_inc;
          end
        end else begin
          stable_nxt = '0;
        end
      end
      fvlw_pkg::MODE_FILL: begin
        fill_time_nxt = fill_inc;
        if (in_data.full_sensor_pin) begin
          if (CMPW'(stable_inc) > CMPW'(debounce_r)) begin
            stable_nxt    = '0;
            fill_time_nxt = '0;
            mode_nxt      = fvlw_pkg::MODE_WAIT;
          end else begin
            stable_nxt = stable_inc;
          end
        end else begin
          stable_nxt = '0;
          // timeout only checked while the pool reads not full
          if (CMPW'(fill_inc) > CMPW'(timeout_r)) begin
            mode_nxt = fvlw_pkg::MODE_EMERG;
          end
        end
      end
      fvlw_pkg::MODE_EMERG: begin
        mode_nxt = fvlw_pkg::MODE_EMERG;
      end
      default: begin
        mode_nxt = fvlw_pkg::MODE_WAIT;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.valve_on = (mode_nxt == fvlw_pkg::MODE_FILL);
    out_data_nxt.led_on   = led_nxt;
    case (mode_nxt)
      fvlw_pkg::MODE_FILL:  out_data_nxt.fill_mode = fvlw_pkg::FILL_MODE_FILL;
      fvlw_pkg::MODE_EMERG: out_data_nxt.fill_mode = fvlw_pkg::FILL_MODE_EMERG;
      default:              out_data_nxt.fill_mode = fvlw_pkg::FILL_MODE_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= fvlw_pkg::DEBOUNCE_RST;
      timeout_r     <= fvlw_pkg::FILL_TIMEOUT_RST;
      blink_norm_r  <= fvlw_pkg::BLINK_NORMAL_RST;
      blink_alarm_r <= fvlw_pkg::BLINK_ALARM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fvlw_pkg::REG_DEBOUNCE:     debounce_r    <= cfg_data;
        fvlw_pkg::REG_FILL_TIMEOUT: timeout_r     <= cfg_data;
        fvlw_pkg::REG_BLINK_NORMAL: blink_norm_r  <= cfg_data;
        fvlw_pkg::REG_BLINK_ALARM:  blink_alarm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= fvlw_pkg::MODE_WAIT;
      stable_r    <= '0;
      fill_time_r <= '0;
      blink_r     <= '0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        stable_r    <= stable_nxt;
        fill_time_r <= fill_time_nxt;
        blink_r     <= blink_nxt;
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: verif/fill_valve_level_watcher_tb.sv
// self-checking testbench for the fill valve level watcher
`timescale 1ns / 100ps

module fill_valve_level_watcher_tb;

  localparam int CNT_W       = fvlw_pkg::COUNTER_BITS_DEF;
  localparam int STALL_LIMIT = 5000;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  fvlw_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  fvlw_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fvlw_pkg::CFG_IDX_W-1:0]  cfg_index = fvlw_pkg::REG_DEBOUNCE;
  logic [fvlw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  fill_valve_level_watcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watcher model: settings and state
  logic [fvlw_pkg::CFG_DATA_W-1:0] cfg_debounce;
  logic [fvlw_pkg::CFG_DATA_W-1:0] cfg_fill_timeout;
  logic [fvlw_pkg::CFG_DATA_W-1:0] cfg_blink_normal;
  logic [fvlw_pkg::CFG_DATA_W-1:0] cfg_blink_alarm;
  fvlw_pkg::mode_t                 water_mode;
  logic [CNT_W-1:0]                level_run;
  logic [CNT_W-1:0]                fill_ticks;
  logic [CNT_W-1:0]                blink_ticks;
  logic                            led_state;

  fvlw_pkg::in_item_t  pending_ticks[$];
  fvlw_pkg::out_item_t expected_outputs[$];
  int        total_ticks   = 0;
  int        results_seen  = 0;
  int        mismatches    = 0;
  int        stall_cycles  = 0;
  int        send_idle_pct = 27;
  int        recv_idle_pct = 59;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // one tick of the watcher: blinker first, then level control
  function automatic fvlw_pkg::out_item_t watch_tick(input fvlw_pkg::in_item_t t);
    logic [CNT_W-1:0]    period;
    fvlw_pkg::out_item_t r;
    period = (water_mode == fvlw_pkg::MODE_EMERG) ? cfg_blink_alarm : cfg_blink_normal;
    blink_ticks = bump(blink_ticks);
    if (blink_ticks >= period) begin
      led_state   = ~led_state;
      blink_ticks = '0;
    end
    case (water_mode)
      fvlw_pkg::MODE_WAIT: begin
        if (!t.low_sensor_pin) begin
          level_run = bump(level_run);
          if (level_run > cfg_debounce) begin
            level_run  = '0;
            fill_ticks = '0;
            water_mode = fvlw_pkg::MODE_FILL;
          end
        end else begin
          level_run = '0;
        end
      end
      fvlw_pkg::MODE_FILL: begin
        fill_ticks = bump(fill_ticks);
        if (t.full_sensor_pin) begin
          level_run = bump(level_run);
          if (level_run > cfg_debounce) begin
            level_run  = '0;
            fill_ticks = '0;
            water_mode = fvlw_pkg::MODE_WAIT;
          end
        end else begin
          level_run = '0;
          // timeout only looked at while the full sensor reads not full
          if (fill_ticks > cfg_fill_timeout) water_mode = fvlw_pkg::MODE_EMERG;
        end
      end
      fvlw_pkg::MODE_EMERG: ;
      default: water_mode = fvlw_pkg::MODE_WAIT;
    endcase
    r.valve_on = (water_mode == fvlw_pkg::MODE_FILL);
    r.led_on   = led_state;
    case (water_mode)
      fvlw_pkg::MODE_FILL:  r.fill_mode = fvlw_pkg::FILL_MODE_FILL;
      fvlw_pkg::MODE_EMERG: r.fill_mode = fvlw_pkg::FILL_MODE_EMERG;
      default:              r.fill_mode = fvlw_pkg::FILL_MODE_WAIT;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // driver: model update on each accepted beat, then load the next tick
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      cfg_debounce     = fvlw_pkg::DEBOUNCE_RST;
      cfg_fill_timeout = fvlw_pkg::FILL_TIMEOUT_RST;
      cfg_blink_normal = fvlw_pkg::BLINK_NORMAL_RST;
      cfg_blink_alarm  = fvlw_pkg::BLINK_ALARM_RST;
      water_mode       = fvlw_pkg::MODE_WAIT;
      level_run        = '0;
      fill_ticks       = '0;
      blink_ticks      = '0;
      led_state        = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fvlw_pkg::REG_DEBOUNCE:     cfg_debounce     = cfg_data;
          fvlw_pkg::REG_FILL_TIMEOUT: cfg_fill_timeout = cfg_data;
          fvlw_pkg::REG_BLINK_NORMAL: cfg_blink_normal = cfg_data;
          fvlw_pkg::REG_BLINK_ALARM:  cfg_blink_alarm  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_outputs.push_back(watch_tick(in_data));
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    fvlw_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          note_failure($sformatf("unexpected result beat %p", out_data));
        end else begin
          want = expected_outputs.pop_front();
          if (out_data.valve_on !== want.valve_on || out_data.led_on !== want.led_on ||
              out_data.fill_mode !== want.fill_mode)
            note_failure($sformatf(
              "result %0d: valve_on exp %b got %b, led_on exp %b got %b, fill_mode exp %0d got %0d",
              results_seen, want.valve_on, out_data.valve_on, want.led_on, out_data.led_on,
              want.fill_mode, out_data.fill_mode));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [fvlw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fvlw_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_tick(input logic low, input logic full);
    pending_ticks.push_back(fvlw_pkg::in_item_t'{low_sensor_pin: low, full_sensor_pin: full});
    total_ticks++;
  endtask

  // runs of sensor readings, mostly steady and mostly near max_len in length
  task automatic add_runs(input int n, input int max_len);
    int kind;
    int len;
    int k;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0) len = $urandom_range(max_len - max_len / 4, max_len);
      else len = $urandom_range(1, max_len);
      for (int j = 0; j < len && k < n; j++) begin
        case (kind)
          0, 1, 2, 3: add_tick(1'b0, 1'b0);
          4, 5, 6:    add_tick(1'b1, 1'b1);
          7:          add_tick(1'b1, 1'b0);
          default:    add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        endcase
        k++;
      end
    end
  endtask

  // wait for every result, then let the pipeline settle
  task automatic settle();
    while (results_seen < total_ticks) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no debounce: every qualifying reading acts at once
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'd0);
    write_reg(fvlw_pkg::REG_FILL_TIMEOUT, 16'd65534);
    write_reg(fvlw_pkg::REG_BLINK_NORMAL, 16'd1);
    add_tick(1'b1, 1'b1); add_tick(1'b1, 1'b0); add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b0); add_tick(1'b0, 1'b0); add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b0); add_tick(1'b0, 1'b1);
    settle();

    // short debounce with broken runs in both directions
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'd2);
    add_tick(1'b0, 1'b0); add_tick(1'b0, 1'b0); add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0); add_tick(1'b0, 1'b0); add_tick(1'b0, 1'b0);
    add_tick(1'b1, 1'b1); add_tick(1'b1, 1'b1); add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1); add_tick(1'b1, 1'b1); add_tick(1'b1, 1'b1);
    settle();

    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'd50);
    write_reg(fvlw_pkg::REG_BLINK_NORMAL, 16'd10);
    add_runs(350, 60);
    settle();

    // thresholds too high to be passed by these short runs
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'd65534);
    write_reg(fvlw_pkg::REG_BLINK_NORMAL, 16'd65535);
    write_reg(fvlw_pkg::REG_BLINK_ALARM, 16'd65535);
    add_runs(100, 20);
    settle();

    send_idle_pct = 59;
    recv_idle_pct = 27;
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 6)));
    write_reg(fvlw_pkg::REG_BLINK_NORMAL, 16'($urandom_range(1, 5)));
    add_runs(300, 10);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'($urandom_range(1, 4)));
    write_reg(fvlw_pkg::REG_BLINK_NORMAL, 16'($urandom_range(1, 7)));
    add_runs(300, 10);
    settle();

    // timeout reachable: emergency latches from here on
    write_reg(fvlw_pkg::REG_DEBOUNCE, 16'd3);
    write_reg(fvlw_pkg::REG_FILL_TIMEOUT, 16'd30);
    write_reg(fvlw_pkg::REG_BLINK_ALARM, 16'd1);
    add_runs(200, 40);
    settle();

    write_reg(fvlw_pkg::REG_FILL_TIMEOUT, 16'd0);
    write_reg(fvlw_pkg::REG_BLINK_ALARM, 16'd3);
    add_runs(100, 10);
    settle();

    if (expected_outputs.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_outputs.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: fill_valve_level_watcher.f
hw/rtl/fvlw_pkg.sv
hw/rtl/fill_valve_level_watcher.sv
verif/fill_valve_level_watcher_tb.sv
